>>> sv/utf8_validating_decoder_assert.svh
// Assertion macros for the UTF-8 validating decoder.
`ifndef UTF8_VALIDATING_DECODER_ASSERT_SVH
`define UTF8_VALIDATING_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U8D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/u8dec_pkg.sv
// Package with types and constants of the UTF-8 validating decoder.
`default_nettype none

package u8dec_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] MAX_CP = 21'h10FFFF;

  localparam logic [7:0] ASCII_LIMIT  = 8'h80;
  localparam logic [7:0] LEAD_MIN     = 8'hC2;
  localparam logic [7:0] LEAD3_MIN    = 8'hE0;
  localparam logic [7:0] LEAD4_MIN    = 8'hF0;
  localparam logic [7:0] LEAD_LIMIT   = 8'hF5;
  localparam logic [7:0] LEAD_E0      = 8'hE0;
  localparam logic [7:0] LEAD_F0      = 8'hF0;
  localparam logic [7:0] LEAD_F4      = 8'hF4;
  localparam logic [7:0] CONT_MASK    = 8'hC0;
  localparam logic [7:0] CONT_TAG     = 8'h80;
  localparam logic [7:0] SECOND_A0    = 8'hA0;
  localparam logic [7:0] SECOND_90    = 8'h90;

  typedef enum logic [1:0] {
    ST_CODE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_END     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RULE_NONE   = 2'd0,
    RULE_MIN_A0 = 2'd1,
    RULE_MIN_90 = 2'd2,
    RULE_MAX_8F = 2'd3
  } rule_t;

endpackage

`default_nettype wire

>>> sv/utf8_validating_decoder.sv
// UTF-8 validating decoder: one byte per beat in, one code point or status out.
//
// Input channel s_axis: one string byte per beat in tdata, tlast on the last
// byte of the string. Output channel m_axis: tdata carries the code point,
// tuser the status (code point, invalid sequence, end after error), tlast
// marks the result that belongs to the string's last byte.
// A byte taken sits in the input register; its result, if any, is then
// registered in the output register, which drives m_axis_tvalid. Bytes that
// only extend a multi-byte sequence, or that follow an error and are not the
// string's last byte, give no beat.
// Outside the stall below, throughput is one byte per cycle: decode is one level
// of byte compares and a 21-bit shift-and-merge between the input and output
// registers, and the input register keeps taking a byte while a result waits
// in the output register.
// When m_axis_tready is low with a result held, the stage only stalls if the
// waiting byte itself produces a result; s_axis_tready then drops once the
// input register is full.
// Reset empties both registers and clears the sequence state, so the first
// byte after reset starts a new string. No clearing pass is needed.
`default_nettype none

module utf8_validating_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tlast,   // last_byte
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [23:0] m_axis_tdata,   // [20:0] scalar value, [23:21] zero
  output      logic [1:0]  m_axis_tuser,   // [1:0] status
  output      logic        m_axis_tlast    // end_of_string
);

  logic                          ivalid;
  logic [7:0]                    ibyte;
  logic                          ilast;

  logic [u8dec_pkg::CP_W-1:0]    partial;
  logic [u8dec_pkg::CP_W-1:0]    partial_next;
  logic [1:0]                    pending;
  logic [1:0]                    pending_next;
  u8dec_pkg::rule_t              rule;
  u8dec_pkg::rule_t              rule_next;
  logic                          first;
  logic                          first_next;
  logic                          dropping;
  logic                          dropping_next;

  logic                          produce;
  logic                          fail;
  logic                          cont_ok;
  logic [u8dec_pkg::CP_W-1:0]    merged;
  logic [u8dec_pkg::CP_W-1:0]    res_cp;
  u8dec_pkg::status_t            res_status;
  logic                          move;

  logic                          ovalid;
  logic [u8dec_pkg::CP_W-1:0]    ocp;
  u8dec_pkg::status_t            ostatus;
  logic                          olast;

  assign merged = {partial[u8dec_pkg::CP_W-7:0], ibyte[5:0]};

  always_comb begin
    cont_ok = ((ibyte & u8dec_pkg::CONT_MASK) == u8dec_pkg::CONT_TAG);
    if (first) begin
      case (rule)
        u8dec_pkg::RULE_MIN_A0: if (ibyte < u8dec_pkg::SECOND_A0) cont_ok = 1'b0;
        u8dec_pkg::RULE_MIN_90: if (ibyte < u8dec_pkg::SECOND_90) cont_ok = 1'b0;
        u8dec_pkg::RULE_MAX_8F: if (ibyte >= u8dec_pkg::SECOND_90) cont_ok = 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    partial_next  = partial;
    pending_next  = pending;
    rule_next     = rule;
    first_next    = first;
    dropping_next = dropping;
    produce       = 1'b0;
    fail          = 1'b0;
    res_cp        = '0;
    res_status    = u8dec_pkg::ST_CODE;

    if (dropping) begin
      if (ilast) begin
        produce    = 1'b1;
        res_status = u8dec_pkg::ST_END;
      end
    end else if (pending == 2'd0) begin
      if (ibyte < u8dec_pkg::ASCII_LIMIT) begin
        produce = 1'b1;
        res_cp  = {{(u8dec_pkg::CP_W-8){1'b0}}, ibyte};
      end else if (ibyte < u8dec_pkg::LEAD_MIN || ibyte >= u8dec_pkg::LEAD_LIMIT) begin
        fail = 1'b1;
      end else begin
        first_next = 1'b1;
        if (ibyte < u8dec_pkg::LEAD3_MIN) begin
          partial_next = {{(u8dec_pkg::CP_W-5){1'b0}}, ibyte[4:0]};
          pending_next = 2'd1;
          rule_next    = u8dec_pkg::RULE_NONE;
        end else if (ibyte < u8dec_pkg::LEAD4_MIN) begin
          partial_next = {{(u8dec_pkg::CP_W-4){1'b0}}, ibyte[3:0]};
          pending_next = 2'd2;
          rule_next    = (ibyte == u8dec_pkg::LEAD_E0) ? u8dec_pkg::RULE_MIN_A0
                                                       : u8dec_pkg::RULE_NONE;
        end else begin
          partial_next = {{(u8dec_pkg::CP_W-3){1'b0}}, ibyte[2:0]};
          pending_next = 2'd3;
          if (ibyte == u8dec_pkg::LEAD_F0) begin
            rule_next = u8dec_pkg::RULE_MIN_90;
          end else if (ibyte == u8dec_pkg::LEAD_F4) begin
            rule_next = u8dec_pkg::RULE_MAX_8F;
          end else begin
            rule_next = u8dec_pkg::RULE_NONE;
          end
        end
        if (ilast) fail = 1'b1;
      end
    end else begin
      if (!cont_ok) begin
        fail = 1'b1;
      end else begin
        partial_next = merged;
        pending_next = pending - 2'd1;
        first_next   = 1'b0;
        rule_next    = u8dec_pkg::RULE_NONE;
        if (pending == 2'd1) begin
          produce      = 1'b1;
          res_cp       = merged;
          partial_next = '0;
        end else if (ilast) begin
          fail = 1'b1;
        end
      end
    end

    if (fail) begin
      produce       = 1'b1;
      res_status    = u8dec_pkg::ST_INVALID;
      res_cp        = '0;
      partial_next  = '0;
      pending_next  = 2'd0;
      rule_next     = u8dec_pkg::RULE_NONE;
      first_next    = 1'b0;
      dropping_next = 1'b1;
    end

    if (produce && ilast) begin
      partial_next  = '0;
      pending_next  = 2'd0;
      rule_next     = u8dec_pkg::RULE_NONE;
      first_next    = 1'b0;
      dropping_next = 1'b0;
    end
  end

  assign move          = ivalid && (!produce || !ovalid || m_axis_tready);
  assign s_axis_tready = !ivalid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      ivalid <= 1'b1;
    end else if (move) begin
      ivalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      ibyte <= s_axis_tdata;
      ilast <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial  <= '0;
      pending  <= 2'd0;
      rule     <= u8dec_pkg::RULE_NONE;
      first    <= 1'b0;
      dropping <= 1'b0;
    end else if (move) begin
      partial  <= partial_next;
      pending  <= pending_next;
      rule     <= rule_next;
      first    <= first_next;
      dropping <= dropping_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (move && produce) begin
      ovalid <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move && produce) begin
      ocp     <= res_cp;
      ostatus <= res_status;
      olast   <= ilast;
    end
  end

  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = {3'b000, ocp};
  assign m_axis_tuser  = ostatus;
  assign m_axis_tlast  = olast;

`include "utf8_validating_decoder_assert.svh"

  `U8D_ASSERT_NOW(a_cp_range, ovalid && ostatus == u8dec_pkg::ST_CODE, ocp <= u8dec_pkg::MAX_CP, "code point above U+10FFFF")
  `U8D_ASSERT_NOW(a_err_zero, ovalid && ostatus != u8dec_pkg::ST_CODE, ocp == '0, "status beat with non-zero code point")
  `U8D_ASSERT_NOW(a_end_last, ovalid && ostatus == u8dec_pkg::ST_END, olast, "end status without end of string")
  `U8D_ASSERT_NEXT(a_end_clear, move && produce && ilast, pending == 2'd0 && !dropping && !first, "state not cleared after end of string")

endmodule

`default_nettype wire
